// File: src/assert_macros.svh
// Assertion macros used by the otsad_acc module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/otsad_pkg.sv
// Package: widths, limits, register indexes and shared types of the detector.
`default_nettype none

package otsad_pkg;

    localparam int SAMPLE_W = 24;
    localparam int MAG_W    = 24;
    localparam int REG_W    = 23;
    localparam int SUM_W    = 27;
    localparam int CNT_W    = 24;
    localparam int IDX_W    = 2;

    localparam logic [REG_W-1:0] SUM_MINIMUM   = REG_W'(100);
    localparam logic [REG_W-1:0] COUNT_MINIMUM = REG_W'(10);

    typedef enum logic [IDX_W-1:0] {
        REG_TRIGGER   = 2'd0,
        REG_SUM_LIMIT = 2'd1,
        REG_WINDOW    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] trigger_level;
        logic [REG_W-1:0] sum_limit;
        logic [REG_W-1:0] window_limit;
    } t_cfg;

    typedef struct packed {
        logic             alarm_pulse;
        logic             collecting;
        logic             alarm_flag;
        logic [SUM_W-1:0] running_sum;
        logic [CNT_W-1:0] running_count;
        logic [SUM_W-1:0] last_sum;
        logic [CNT_W-1:0] last_count;
    } t_result;

endpackage

`default_nettype wire

// File: src/otsad_in_if.sv
// Interface: input sample channel with valid/ready handshake.
`default_nettype none

interface otsad_in_if;
    import otsad_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] zero_level;

    modport source (output valid, output sample, output zero_level, input ready);
    modport sink   (input valid, input sample, input zero_level, output ready);
endinterface

`default_nettype wire

// File: src/otsad_out_if.sv
// Interface: result channel with valid/ready handshake.
`default_nettype none

interface otsad_out_if;
    import otsad_pkg::*;

    logic             valid;
    logic             ready;
    logic             alarm_pulse;
    logic             collecting;
    logic             alarm_flag;
    logic [SUM_W-1:0] running_sum;
    logic [CNT_W-1:0] running_count;
    logic [SUM_W-1:0] last_sum;
    logic [CNT_W-1:0] last_count;

    modport source (
        output valid, output alarm_pulse, output collecting, output alarm_flag,
        output running_sum, output running_count, output last_sum, output last_count,
        input ready
    );
    modport sink (
        input valid, input alarm_pulse, input collecting, input alarm_flag,
        input running_sum, input running_count, input last_sum, input last_count,
        output ready
    );
endinterface

`default_nettype wire

// File: src/otsad_acc.sv
// Collection state, accumulation and alarm decision; the state is the result register.
`default_nettype none
`include "assert_macros.svh"

module otsad_acc (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [otsad_pkg::MAG_W-1:0] i_mag,
    input  wire otsad_pkg::t_cfg           i_cfg,
    output otsad_pkg::t_result             o_res
);
    import otsad_pkg::*;

    logic             r_pulse, n_pulse;
    logic             r_collect, n_collect;
    logic             r_alarm, n_alarm;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_saved_sum, n_saved_sum;
    logic [CNT_W-1:0] r_saved_count, n_saved_count;

    logic [MAG_W-1:0] excess;
    logic [MAG_W-1:0] trig_ext;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat;
    logic [CNT_W-1:0] cnt_inc;
    logic [REG_W-1:0] sum_eff;
    logic [REG_W-1:0] win_eff;
    logic             start;

    assign trig_ext = {1'b0, i_cfg.trigger_level};
    assign excess   = (i_mag > trig_ext) ? (i_mag - trig_ext) : '0;
    assign start    = (excess > trig_ext);
    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(excess);
    assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign cnt_inc  = (r_count != '1) ? (r_count + CNT_W'(1)) : r_count;
    assign sum_eff  = (i_cfg.sum_limit > SUM_MINIMUM) ? i_cfg.sum_limit : SUM_MINIMUM;
    assign win_eff  = (i_cfg.window_limit > COUNT_MINIMUM) ? i_cfg.window_limit : COUNT_MINIMUM;

    always_comb begin
        n_pulse       = 1'b0;
        n_collect     = r_collect;
        n_alarm       = r_alarm;
        n_sum         = r_sum;
        n_count       = r_count;
        n_saved_sum   = r_saved_sum;
        n_saved_count = r_saved_count;
        if (r_collect) begin
            n_count = cnt_inc;
            n_sum   = sum_sat;
            if ((sum_sat > SUM_W'(sum_eff)) && !r_alarm) begin
                n_collect     = 1'b0;
                n_alarm       = 1'b1;
                n_saved_count = cnt_inc;
                n_saved_sum   = sum_sat;
                n_count       = '0;
                n_sum         = '0;
                n_pulse       = 1'b1;
            end else if (cnt_inc > CNT_W'(win_eff)) begin
                n_collect = 1'b0;
                n_alarm   = 1'b0;
            end
        end else if (start) begin
            n_collect     = 1'b1;
            n_alarm       = 1'b0;
            n_saved_count = '0;
            n_saved_sum   = '0;
            n_count       = '0;
            n_sum         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse       <= 1'b0;
            r_collect     <= 1'b0;
            r_alarm       <= 1'b0;
            r_sum         <= '0;
            r_count       <= '0;
            r_saved_sum   <= '0;
            r_saved_count <= '0;
        end else if (i_step) begin
            r_pulse       <= n_pulse;
            r_collect     <= n_collect;
            r_alarm       <= n_alarm;
            r_sum         <= n_sum;
            r_count       <= n_count;
            r_saved_sum   <= n_saved_sum;
            r_saved_count <= n_saved_count;
        end
    end

    assign o_res.alarm_pulse   = r_pulse;
    assign o_res.collecting    = r_collect;
    assign o_res.alarm_flag    = r_alarm;
    assign o_res.running_sum   = r_sum;
    assign o_res.running_count = r_count;
    assign o_res.last_sum      = r_saved_sum;
    assign o_res.last_count    = r_saved_count;

    `ASSERT_SAME(a_pulse_ends_collection, i_clk, i_rst_n, r_pulse,
        !r_collect && r_alarm && (r_sum == '0) && (r_count == '0))
    `ASSERT_SAME(a_collect_excludes_alarm, i_clk, i_rst_n, r_collect, !r_alarm)
    `ASSERT_NEXT(a_idle_without_start, i_clk, i_rst_n, i_step && !r_collect && !start,
        !r_collect && !r_pulse)

endmodule

`default_nettype wire

// File: src/over_threshold_sum_alarm_detector.sv
// Top level: configuration registers, input stage and result handshake of the detector.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    sample, zero_level (signed 24)
//  o_out    out  valid/ready    alarm_pulse, collecting, alarm_flag, running_sum,
//                               running_count, last_sum, last_count
//  cfg      in   i_cfg_we       i_cfg_idx (2), i_cfg_data (23)
//
// One item per cycle sustained while o_out.ready is high; the result is registered after the input stage.
// The input stage registers the magnitude, the second stage accumulates and holds the result.
// A stalled result holds both stages; the input stage still fills while the result waits.
// Synchronous active-low reset clears valids, configuration registers and collection state.
`default_nettype none

module over_threshold_sum_alarm_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    otsad_in_if.sink                           i_in,
    otsad_out_if.source                        o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [otsad_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [otsad_pkg::REG_W-1:0]   i_cfg_data
);
    import otsad_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [MAG_W-1:0] r_mag;
    logic             r_out_valid;
    logic [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] diff_abs;
    logic             out_load;
    logic             in_take;
    t_result          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TRIGGER:   r_cfg.trigger_level <= i_cfg_data;
                REG_SUM_LIMIT: r_cfg.sum_limit     <= i_cfg_data;
                REG_WINDOW:    r_cfg.window_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign diff     = {i_in.sample[SAMPLE_W-1], i_in.sample}
                    - {i_in.zero_level[SAMPLE_W-1], i_in.zero_level};
    assign diff_abs = diff[SAMPLE_W] ? (~diff + (SAMPLE_W + 1)'(1)) : diff;

    assign out_load   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || out_load;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mag <= diff_abs[MAG_W-1:0];
        end
    end

    otsad_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (out_load),
        .i_mag   (r_mag),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.alarm_pulse   = res.alarm_pulse;
    assign o_out.collecting    = res.collecting;
    assign o_out.alarm_flag    = res.alarm_flag;
    assign o_out.running_sum   = res.running_sum;
    assign o_out.running_count = res.running_count;
    assign o_out.last_sum      = res.last_sum;
    assign o_out.last_count    = res.last_count;

endmodule

`default_nettype wire
